FILE: design/ucs_pkg.sv
package ucs_pkg;

   localparam int MAX_LEN = 4096;
   localparam int POS_W   = $clog2(MAX_LEN + 1);
   localparam int PORT_W  = 31;
   localparam int MASK_W  = 12;

   localparam logic [POS_W-1:0]  POS_MAX  = POS_W'(MAX_LEN);
   localparam logic [PORT_W-1:0] PORT_MAX = {PORT_W{1'b1}};

   // present_mask bit positions
   localparam int F_SCHEME = 0;
   localparam int F_AUTH   = 1;
   localparam int F_USER   = 2;
   localparam int F_PASS   = 3;
   localparam int F_HOST   = 4;
   localparam int F_PORT   = 5;
   localparam int F_PATH   = 6;
   localparam int F_DIR    = 7;
   localparam int F_BASE   = 8;
   localparam int F_QUERY  = 9;
   localparam int F_FRAG   = 10;
   localparam int F_LONG   = 11;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;

   typedef enum logic [2:0] {
      M_START,
      M_PROTO,
      M_COLON,
      M_SLASH1,
      M_AUTH,
      M_PATH,
      M_QUERY,
      M_FRAG
   } mode_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] present_mask;
      logic [POS_W-1:0]  scheme_len;
      logic [POS_W-1:0]  authority_start;
      logic [POS_W-1:0]  authority_end;
      logic [POS_W-1:0]  userinfo_colon;
      logic [POS_W-1:0]  host_start;
      logic [POS_W-1:0]  host_end;
      logic [PORT_W-1:0] port_value;
      logic [POS_W-1:0]  path_start;
      logic [POS_W-1:0]  path_end;
      logic [POS_W-1:0]  last_slash;
      logic [POS_W-1:0]  fragment_start;
   } rsp_type;

   typedef struct packed {
      mode_type          mode;
      logic [POS_W-1:0]  byte_pos;
      logic [POS_W-1:0]  scheme_len;
      logic [POS_W-1:0]  auth_start;
      logic [POS_W-1:0]  auth_end;
      logic              auth_seen;
      logic [POS_W-1:0]  first_colon;
      logic              colon_ok;
      logic [POS_W-1:0]  last_at;
      logic              at_ok;
      logic [POS_W-1:0]  last_colon;
      logic              lcolon_ok;
      logic              digits_only;
      logic [PORT_W-1:0] port_accum;
      logic              port_overflow;
      logic [POS_W-1:0]  path_start;
      logic [POS_W-1:0]  path_end;
      logic [POS_W-1:0]  last_slash;
      logic              slash_ok;
      logic [POS_W-1:0]  frag_start;
      logic [MASK_W-1:0] flags;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      mode:          M_START,
      byte_pos:      '0,
      scheme_len:    '0,
      auth_start:    '0,
      auth_end:      '0,
      auth_seen:     1'b0,
      first_colon:   '0,
      colon_ok:      1'b0,
      last_at:       '0,
      at_ok:         1'b0,
      last_colon:    '0,
      lcolon_ok:     1'b0,
      digits_only:   1'b1,
      port_accum:    '0,
      port_overflow: 1'b0,
      path_start:    '0,
      path_end:      '0,
      last_slash:    '0,
      slash_ok:      1'b0,
      frag_start:    '0,
      flags:         '0
   };

   // position plus one, held at MAX_LEN
   function automatic logic [POS_W-1:0] sat1(input logic [POS_W-1:0] p);
      return (p >= POS_MAX) ? POS_MAX : p + POS_W'(1);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

FILE: design/uri_component_splitter.sv
// Channel   Direction  Payload                    Transfer
// req_      in         ucs_pkg::req_type          req_valid & req_ready
// rsp_      out        ucs_pkg::rsp_type          rsp_valid & rsp_ready
//
// One byte is taken per cycle while req_ready is high; the parse state registers update on each transfer.
// The byte marked last hands a finalised snapshot to a second register, and when the result
// register is free or being read, the mask and spans are resolved from it into the result register.
// Reset (synchronous) returns the parser to scheme scan and empties both stages.
// A stalled result holds; bytes keep flowing until the snapshot stage is also full.
module uri_component_splitter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ucs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ucs_pkg::rsp_type rsp_data
);

   ucs_pkg::parse_state_type state_ff, state_in;
   ucs_pkg::parse_state_type snap_ff, snap_in;
   logic                     snap_valid_ff, snap_valid_in;
   ucs_pkg::rsp_type         rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   ucs_pkg::mode_type        mode_w;
   ucs_pkg::parse_state_type work;
   logic                     req_fire, snap_move;
   logic [7:0]               c;
   logic                     c_scheme, c_term;

   assign c        = req_data.char_byte;
   assign c_scheme = ucs_pkg::is_alpha(c) || ucs_pkg::is_digit(c) || c == ucs_pkg::CH_PLUS
                     || c == ucs_pkg::CH_MINUS || c == ucs_pkg::CH_DOT;
   assign c_term   = c == ucs_pkg::CH_SLASH || c == ucs_pkg::CH_QUEST
                     || c == ucs_pkg::CH_HASH;

   assign snap_move = snap_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !snap_valid_ff || snap_move;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next parse mode after this byte, including the hand-over into path
   always_comb begin
      ucs_pkg::mode_type path_next;
      path_next = (c == ucs_pkg::CH_QUEST) ? ucs_pkg::M_QUERY :
                  (c == ucs_pkg::CH_HASH)  ? ucs_pkg::M_FRAG  : ucs_pkg::M_PATH;
      case (state_ff.mode)
         ucs_pkg::M_START:
            mode_w = ucs_pkg::is_alpha(c) ? ucs_pkg::M_PROTO : path_next;
         ucs_pkg::M_PROTO:
            mode_w = (c == ucs_pkg::CH_COLON) ? ucs_pkg::M_COLON :
                     c_scheme ? ucs_pkg::M_PROTO : path_next;
         ucs_pkg::M_COLON:
            mode_w = (c == ucs_pkg::CH_SLASH) ? ucs_pkg::M_SLASH1 : path_next;
         ucs_pkg::M_SLASH1:
            mode_w = (c == ucs_pkg::CH_SLASH) ? ucs_pkg::M_AUTH : path_next;
         ucs_pkg::M_AUTH:
            mode_w = c_term ? path_next : ucs_pkg::M_AUTH;
         ucs_pkg::M_PATH:
            mode_w = path_next;
         ucs_pkg::M_QUERY:
            mode_w = (c == ucs_pkg::CH_HASH) ? ucs_pkg::M_FRAG : ucs_pkg::M_QUERY;
         ucs_pkg::M_FRAG:
            mode_w = ucs_pkg::M_FRAG;
         default:
            mode_w = ucs_pkg::M_FRAG;
      endcase
   end

   // offsets and flags for this byte, then the end-of-text fix-up
   always_comb begin
      logic [ucs_pkg::POS_W-1:0] p, ps, fin_end;
      logic                      to_path, in_path, sl1_fix;
      logic [ucs_pkg::PORT_W+3:0] v;

      p       = state_ff.byte_pos;
      ps      = '0;
      to_path = 1'b0;
      in_path = 1'b0;
      sl1_fix = 1'b0;
      v       = {1'b0, state_ff.port_accum, 3'b000} + {3'b000, state_ff.port_accum, 1'b0}
                + {(ucs_pkg::PORT_W)'(0), c[3:0]};

      work          = state_ff;
      work.mode     = mode_w;
      work.byte_pos = ucs_pkg::sat1(p);
      if (p >= ucs_pkg::POS_MAX) begin
         work.flags[ucs_pkg::F_LONG] = 1'b1;
      end

      case (state_ff.mode)
         ucs_pkg::M_START: begin
            if (!ucs_pkg::is_alpha(c)) begin
               to_path = 1'b1;
            end
         end
         ucs_pkg::M_PROTO: begin
            if (c == ucs_pkg::CH_COLON) begin
               work.scheme_len               = p;
               work.flags[ucs_pkg::F_SCHEME] = 1'b1;
            end else if (!c_scheme) begin
               to_path = 1'b1;
            end
         end
         ucs_pkg::M_COLON: begin
            if (c != ucs_pkg::CH_SLASH) begin
               to_path = 1'b1;
               ps      = p;
            end
         end
         ucs_pkg::M_SLASH1: begin
            if (c == ucs_pkg::CH_SLASH) begin
               work.auth_start = ucs_pkg::sat1(p);
               work.auth_end   = ucs_pkg::sat1(p);
               work.auth_seen  = 1'b1;
            end else begin
               to_path = 1'b1;
               sl1_fix = 1'b1;
               ps      = (p != '0) ? p - ucs_pkg::POS_W'(1) : '0;
            end
         end
         ucs_pkg::M_AUTH: begin
            if (c_term) begin
               work.auth_end = p;
               to_path       = 1'b1;
               ps            = p;
            end else if (c == ucs_pkg::CH_COLON) begin
               if (!state_ff.colon_ok) begin
                  work.first_colon = p;
                  work.colon_ok    = 1'b1;
               end
               work.last_colon    = p;
               work.lcolon_ok     = 1'b1;
               work.digits_only   = 1'b1;
               work.port_accum    = '0;
               work.port_overflow = 1'b0;
            end else if (c == ucs_pkg::CH_AT) begin
               work.last_at       = p;
               work.at_ok         = 1'b1;
               work.digits_only   = 1'b1;
               work.port_accum    = '0;
               work.port_overflow = 1'b0;
            end else if (ucs_pkg::is_digit(c)) begin
               if (!state_ff.port_overflow) begin
                  if (v > {4'd0, ucs_pkg::PORT_MAX}) begin
                     work.port_overflow = 1'b1;
                  end else begin
                     work.port_accum = v[ucs_pkg::PORT_W-1:0];
                  end
               end
            end else begin
               work.digits_only = 1'b0;
            end
         end
         ucs_pkg::M_PATH: begin
            in_path = 1'b1;
         end
         ucs_pkg::M_QUERY: begin
            if (c == ucs_pkg::CH_HASH) begin
               work.frag_start              = ucs_pkg::sat1(p);
               work.flags[ucs_pkg::F_FRAG]  = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (to_path) begin
         in_path         = 1'b1;
         work.path_start = ps;
         work.path_end   = ps;
         work.slash_ok   = sl1_fix;
         if (sl1_fix) begin
            work.last_slash = ps;
         end
      end

      // the same byte handled again as a path byte
      if (in_path) begin
         if (c == ucs_pkg::CH_QUEST) begin
            work.path_end                = p;
            work.flags[ucs_pkg::F_QUERY] = 1'b1;
         end else if (c == ucs_pkg::CH_HASH) begin
            work.path_end               = p;
            work.frag_start             = ucs_pkg::sat1(p);
            work.flags[ucs_pkg::F_FRAG] = 1'b1;
         end else if (c == ucs_pkg::CH_SLASH) begin
            work.last_slash = p;
            work.slash_ok   = 1'b1;
         end
      end

      // close whatever was open when the text ends
      fin_end = work.byte_pos;
      snap_in = work;
      case (work.mode)
         ucs_pkg::M_START, ucs_pkg::M_PROTO: begin
            snap_in.path_start = '0;
            snap_in.path_end   = fin_end;
            snap_in.slash_ok   = 1'b0;
         end
         ucs_pkg::M_COLON: begin
            snap_in.path_start = fin_end;
            snap_in.path_end   = fin_end;
            snap_in.slash_ok   = 1'b0;
         end
         ucs_pkg::M_SLASH1: begin
            snap_in.path_start = fin_end - ucs_pkg::POS_W'(1);
            snap_in.path_end   = fin_end;
            snap_in.last_slash = fin_end - ucs_pkg::POS_W'(1);
            snap_in.slash_ok   = 1'b1;
         end
         ucs_pkg::M_AUTH: begin
            snap_in.auth_end   = fin_end;
            snap_in.path_start = fin_end;
            snap_in.path_end   = fin_end;
            snap_in.slash_ok   = 1'b0;
         end
         ucs_pkg::M_PATH: begin
            snap_in.path_end = fin_end;
         end
         default: begin
         end
      endcase

      state_in = state_ff;
      if (req_fire) begin
         state_in = req_data.is_last ? ucs_pkg::STATE_RESET : work;
      end
   end

   // resolve mask, host span and port from the snapshot
   always_comb begin
      logic [ucs_pkg::MASK_W-1:0] m;
      logic [ucs_pkg::POS_W-1:0]  hs_t;

      m    = snap_ff.flags;
      hs_t = snap_ff.at_ok ? ucs_pkg::sat1(snap_ff.last_at) : snap_ff.auth_start;

      rsp_in                = '0;
      rsp_in.path_start     = snap_ff.path_start;
      rsp_in.path_end       = snap_ff.path_end;

      if (snap_ff.auth_seen && snap_ff.auth_end > snap_ff.auth_start) begin
         m[ucs_pkg::F_AUTH]     = 1'b1;
         rsp_in.authority_start = snap_ff.auth_start;
         rsp_in.authority_end   = snap_ff.auth_end;
         if (snap_ff.at_ok) begin
            m[ucs_pkg::F_USER] = 1'b1;
            if (snap_ff.colon_ok && snap_ff.first_colon < snap_ff.last_at) begin
               m[ucs_pkg::F_PASS]    = 1'b1;
               rsp_in.userinfo_colon = snap_ff.first_colon;
            end
         end
         if (hs_t < snap_ff.auth_end) begin
            m[ucs_pkg::F_HOST] = 1'b1;
            rsp_in.host_start  = hs_t;
            rsp_in.host_end    = snap_ff.auth_end;
            if (snap_ff.lcolon_ok && snap_ff.last_colon > hs_t
                && ucs_pkg::sat1(snap_ff.last_colon) < snap_ff.auth_end
                && snap_ff.digits_only) begin
               rsp_in.host_end = snap_ff.last_colon;
               if (!snap_ff.port_overflow) begin
                  m[ucs_pkg::F_PORT] = 1'b1;
                  rsp_in.port_value  = snap_ff.port_accum;
               end
            end
         end
      end

      if (snap_ff.path_end > snap_ff.path_start) begin
         m[ucs_pkg::F_PATH] = 1'b1;
         m[ucs_pkg::F_BASE] = 1'b1;
         if (snap_ff.slash_ok) begin
            m[ucs_pkg::F_DIR] = 1'b1;
            rsp_in.last_slash = snap_ff.last_slash;
         end
      end

      if (m[ucs_pkg::F_SCHEME]) begin
         rsp_in.scheme_len = snap_ff.scheme_len;
      end
      if (m[ucs_pkg::F_FRAG]) begin
         rsp_in.fragment_start = snap_ff.frag_start;
      end
      rsp_in.present_mask = m;
   end

   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (req_fire && req_data.is_last) begin
         snap_valid_in = 1'b1;
      end else if (snap_move) begin
         snap_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (snap_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ucs_pkg::STATE_RESET;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload: hold unless a new snapshot or result moves in
   always_ff @(posedge clock) begin
      if (req_fire && req_data.is_last) begin
         snap_ff <= snap_in;
      end
      if (snap_move) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
